FILE: hw/rtl/hwtc_pkg.sv
package hwtc_pkg;

  // CRC-8 parameters of the sensor frame.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte positions within the six-byte frame.
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // Status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

  // Conversion to hundredths: floor(raw * SCALE / DIVISOR) - OFFSET.
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [14:0] HUM_SCALE   = 15'd12500;
  localparam logic [14:0] HUM_OFFSET  = 15'd600;
  localparam logic [16:0] DIVISOR     = 17'd65535;

  // Checked frame handed from the frame stage to the conversion stage.
  typedef struct packed {
    logic        status;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
  } frame_res_t;

  // One CRC-8 byte update, MSB first, no reflection.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/hwtc_frame.sv
module hwtc_frame (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   in_start,
  output logic                   res_valid,
  input  logic                   res_ready,
  output hwtc_pkg::frame_res_t   res
);

  // Input register.
  logic       ib_valid;
  logic [7:0] ib_byte;
  logic       ib_start;

  // Frame state.
  logic [2:0] byte_pos;
  logic [7:0] running_crc;
  logic [15:0] temp_word;
  logic [15:0] hum_word;
  logic        temp_crc_good;

  logic [2:0] pos;
  logic       is_last;
  logic       slot_free;
  logic       take;
  logic       frame_ok;

  // A start flag or an unused position restarts the frame.
  always_comb begin
    if (ib_start || byte_pos > hwtc_pkg::POS_H_CRC) begin
      pos = hwtc_pkg::POS_T_MSB;
    end else begin
      pos = byte_pos;
    end
  end

  assign is_last   = (pos == hwtc_pkg::POS_H_CRC);
  assign slot_free = !res_valid || res_ready;
  // Only the closing byte needs room in the result register.
  assign take      = ib_valid && (!is_last || slot_free);
  assign in_ready  = !ib_valid || take;
  assign frame_ok  = temp_crc_good && (running_crc == ib_byte);

  // Input register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (in_ready) begin
      ib_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      ib_byte  <= in_byte;
      ib_start <= in_start;
    end
  end

  // Per-byte frame update.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos      <= hwtc_pkg::POS_T_MSB;
      running_crc   <= hwtc_pkg::CRC_INIT;
      temp_crc_good <= 1'b0;
    end else if (take) begin
      case (pos)
        hwtc_pkg::POS_T_MSB: begin
          running_crc     <= hwtc_pkg::crc8_feed(hwtc_pkg::CRC_INIT, ib_byte);
          temp_word[15:8] <= ib_byte;
          byte_pos        <= hwtc_pkg::POS_T_LSB;
        end
        hwtc_pkg::POS_T_LSB: begin
          running_crc    <= hwtc_pkg::crc8_feed(running_crc, ib_byte);
          temp_word[7:0] <= ib_byte;
          byte_pos       <= hwtc_pkg::POS_T_CRC;
        end
        hwtc_pkg::POS_T_CRC: begin
          temp_crc_good <= (running_crc == ib_byte);
          running_crc   <= hwtc_pkg::CRC_INIT;
          byte_pos      <= hwtc_pkg::POS_H_MSB;
        end
        hwtc_pkg::POS_H_MSB: begin
          running_crc    <= hwtc_pkg::crc8_feed(hwtc_pkg::CRC_INIT, ib_byte);
          hum_word[15:8] <= ib_byte;
          byte_pos       <= hwtc_pkg::POS_H_LSB;
        end
        hwtc_pkg::POS_H_LSB: begin
          running_crc   <= hwtc_pkg::crc8_feed(running_crc, ib_byte);
          hum_word[7:0] <= ib_byte;
          byte_pos      <= hwtc_pkg::POS_H_CRC;
        end
        default: begin
          running_crc <= hwtc_pkg::CRC_INIT;
          byte_pos    <= hwtc_pkg::POS_T_MSB;
        end
      endcase
    end
  end

  // Result register: loaded by the closing byte, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && is_last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (take && is_last) begin
      res.status   <= frame_ok ? hwtc_pkg::STATUS_OK : hwtc_pkg::STATUS_CRC_ERR;
      res.temp_raw <= frame_ok ? temp_word : 16'd0;
      res.hum_raw  <= frame_ok ? hum_word : 16'd0;
    end
  end

endmodule

FILE: hw/rtl/hwtc_conv.sv
module hwtc_conv (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  output logic                   res_ready,
  input  hwtc_pkg::frame_res_t   res,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_status,
  output logic [15:0]            out_temp_raw,
  output logic [15:0]            out_hum_raw,
  output logic signed [14:0]     out_temp_centi,
  output logic signed [14:0]     out_hum_centi
);

  // Product stage.
  logic                 p_valid;
  hwtc_pkg::frame_res_t p_res;
  logic [30:0]          p_tprod;
  logic [30:0]          p_hprod;
  logic                 p_ready;
  logic                 o_free;

  logic [14:0]          t_quot;
  logic [14:0]          h_quot;
  logic signed [15:0]   t_centi;
  logic signed [15:0]   h_centi;

  // Divide by 2^16 - 1: take the high half, then fix up once with the
  // folded remainder, which stays below twice the divisor.
  function automatic logic [14:0] div_65535(input logic [30:0] x);
    logic [14:0] q;
    logic [16:0] r;
    q = x[30:16];
    r = {1'b0, x[15:0]} + {2'b00, q};
    if (r >= hwtc_pkg::DIVISOR) begin
      q = q + 15'd1;
    end
    return q;
  endfunction

  assign o_free    = !out_valid || out_ready;
  assign p_ready   = !p_valid || o_free;
  assign res_ready = p_ready;

  // Scale both raw words.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= res_valid;
    end
    if (p_ready && res_valid) begin
      p_res   <= res;
      p_tprod <= 31'(res.temp_raw) * 31'(hwtc_pkg::TEMP_SCALE);
      p_hprod <= 31'(res.hum_raw) * 31'(hwtc_pkg::HUM_SCALE);
    end
  end

  // Quotient and offset.
  assign t_quot  = div_65535(p_tprod);
  assign h_quot  = div_65535(p_hprod);
  assign t_centi = $signed({1'b0, t_quot}) - $signed({1'b0, hwtc_pkg::TEMP_OFFSET});
  assign h_centi = $signed({1'b0, h_quot}) - $signed({1'b0, hwtc_pkg::HUM_OFFSET});

  // Output register; an error frame reports zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= p_valid;
    end
    if (o_free && p_valid) begin
      out_status   <= p_res.status;
      out_temp_raw <= p_res.temp_raw;
      out_hum_raw  <= p_res.hum_raw;
      if (p_res.status == hwtc_pkg::STATUS_OK) begin
        out_temp_centi <= t_centi[14:0];
        out_hum_centi  <= h_centi[14:0];
      end else begin
        out_temp_centi <= 15'sd0;
        out_hum_centi  <= 15'sd0;
      end
    end
  end

endmodule

FILE: hw/rtl/humidity_temp_frame_checker.sv
// Each result passes the frame result, product and output registers to the master side.
// Throughput: one byte per cycle while the closing byte is not held; one result per six bytes.
// Results stall behind the output register while earlier bytes of the next frame are still taken.
// Reset clears all valid flags, sets the byte position to the first byte and the CRC to 0xFF.
module humidity_temp_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [0] status, [16:1] temp_raw, [32:17] hum_raw,
                                      // [47:33] temp_centi, [62:48] hum_centi, [63] zero
);

  logic                 res_valid;
  logic                 res_ready;
  hwtc_pkg::frame_res_t res;

  logic                 status;
  logic [15:0]          temp_raw;
  logic [15:0]          hum_raw;
  logic signed [14:0]   temp_centi;
  logic signed [14:0]   hum_centi;

  // Byte assembly and CRC check.
  hwtc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_start  (s_axis_tuser),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Conversion to hundredths and output register.
  hwtc_conv u_conv (
    .clk            (clk),
    .rst            (rst),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_status     (status),
    .out_temp_raw   (temp_raw),
    .out_hum_raw    (hum_raw),
    .out_temp_centi (temp_centi),
    .out_hum_centi  (hum_centi)
  );

  assign m_axis_tdata = {1'b0, hum_centi, temp_centi, hum_raw, temp_raw, status};

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RX_HOLD_CYCLES = 300;

  // One byte request toward the frame checker.
  typedef struct {
    logic [7:0] data;
    logic       start;
  } rx_item_t;

  // One decoded sensor reading as it leaves the checker.
  typedef struct {
    logic               status;
    logic        [15:0] temp_raw;
    logic        [15:0] hum_raw;
    logic signed [14:0] temp_centi;
    logic signed [14:0] hum_centi;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  rx_item_t rx_items[$];
  reading_t expected_readings[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  in_taken = 1'b0;
  bit  rx_hold_req = 1'b0;
  int  rx_hold_left = 0;
  int  stall_cycles = 0;
  int  fail_count = 0;
  int  bytes_taken = 0;
  int  readings_good = 0;
  int  readings_bad = 0;

  // Frame tracker state, mirrors what the checker holds.
  logic [2:0]  trk_pos = hwtc_pkg::POS_T_MSB;
  logic [7:0]  trk_crc = hwtc_pkg::CRC_INIT;
  logic [15:0] trk_temp = 16'h0000;
  logic [15:0] trk_hum = 16'h0000;
  logic        trk_temp_ok = 1'b0;

  humidity_temp_frame_checker u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // CRC-8, polynomial 0x31, one byte, most significant bit first.
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ hwtc_pkg::CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc_byte(crc_byte(hwtc_pkg::CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Advance the frame tracker by one byte and queue a reading when a frame closes.
  function automatic void track_byte(input logic [7:0] b, input logic start);
    logic [2:0]  pos;
    reading_t    r;
    int unsigned t_scaled;
    int unsigned h_scaled;
    int          tc;
    int          hc;
    pos = trk_pos;
    if (start) begin
      pos = hwtc_pkg::POS_T_MSB;
      trk_crc = hwtc_pkg::CRC_INIT;
    end
    if (pos > hwtc_pkg::POS_H_CRC) begin
      pos = hwtc_pkg::POS_T_MSB;
    end
    case (pos)
      hwtc_pkg::POS_T_MSB: begin
        trk_crc = crc_byte(hwtc_pkg::CRC_INIT, b);
        trk_temp[15:8] = b;
      end
      hwtc_pkg::POS_T_LSB: begin
        trk_crc = crc_byte(trk_crc, b);
        trk_temp[7:0] = b;
      end
      hwtc_pkg::POS_T_CRC: begin
        trk_temp_ok = (trk_crc == b);
        trk_crc = hwtc_pkg::CRC_INIT;
      end
      hwtc_pkg::POS_H_MSB: begin
        trk_crc = crc_byte(hwtc_pkg::CRC_INIT, b);
        trk_hum[15:8] = b;
      end
      hwtc_pkg::POS_H_LSB: begin
        trk_crc = crc_byte(trk_crc, b);
        trk_hum[7:0] = b;
      end
      default: begin
        if (trk_temp_ok && (trk_crc == b)) begin
          t_scaled = (32'(trk_temp) * 32'd17500) / 32'd65535;
          h_scaled = (32'(trk_hum) * 32'd12500) / 32'd65535;
          tc = int'(t_scaled) - 4500;
          hc = int'(h_scaled) - 600;
          r.status     = hwtc_pkg::STATUS_OK;
          r.temp_raw   = trk_temp;
          r.hum_raw    = trk_hum;
          r.temp_centi = tc[14:0];
          r.hum_centi  = hc[14:0];
        end else begin
          r.status     = hwtc_pkg::STATUS_CRC_ERR;
          r.temp_raw   = 16'h0000;
          r.hum_raw    = 16'h0000;
          r.temp_centi = 15'sd0;
          r.hum_centi  = 15'sd0;
        end
        trk_crc = hwtc_pkg::CRC_INIT;
        expected_readings.push_back(r);
      end
    endcase
    trk_pos = (pos == hwtc_pkg::POS_H_CRC) ? hwtc_pkg::POS_T_MSB : pos + 3'd1;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic start);
    rx_item_t it;
    it.data  = b;
    it.start = start;
    rx_items.push_back(it);
  endfunction

  // Queue one full six-byte frame, optionally with either or both CRC bytes corrupted.
  function automatic void push_frame(input logic [15:0] tw, input logic [15:0] hw,
                                     input logic start, input bit bad_t, input bit bad_h);
    logic [7:0] tcrc;
    logic [7:0] hcrc;
    tcrc = word_crc(tw);
    hcrc = word_crc(hw);
    if (bad_t) tcrc ^= 8'(1 << $urandom_range(7));
    if (bad_h) hcrc ^= 8'(1 << $urandom_range(7));
    push_byte(tw[15:8], start);
    push_byte(tw[7:0], 1'b0);
    push_byte(tcrc, 1'b0);
    push_byte(hw[15:8], 1'b0);
    push_byte(hw[7:0], 1'b0);
    push_byte(hcrc, 1'b0);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly good frames with random content, plus corrupt CRCs, cut frames and noise.
  function automatic void queue_random_traffic(input int n_bytes);
    int goal;
    int pick;
    int k;
    bit need_sync;
    goal = rx_items.size() + n_bytes;
    need_sync = 1'b1;
    while (rx_items.size() < goal) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        push_frame(rand_word(), rand_word(), need_sync ? 1'b1 : 1'($urandom_range(1)),
                   $urandom_range(9) == 0, $urandom_range(9) == 0);
        need_sync = 1'b0;
      end else if (pick < 90) begin
        k = $urandom_range(1, 5);
        for (int i = 0; i < k; i++) push_byte(8'($urandom), i == 0);
        need_sync = 1'b1;
      end else begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) push_byte(8'($urandom), $urandom_range(3) == 0);
        need_sync = 1'b1;
      end
    end
  endfunction

  // Sender: offers the next byte at the falling edge, with random gaps.
  always @(negedge clk) begin
    rx_item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (rx_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = rx_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.data;
        s_axis_tuser  <= it.start;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // Receiver: random stalls, and a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = RX_HOLD_CYCLES;
      rx_hold_req = 1'b0;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: tracks accepted bytes, checks results, and runs the watchdog.
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    bit       moved;
    if (!rst) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        track_byte(s_axis_tdata, s_axis_tuser);
        bytes_taken++;
        in_taken = 1'b1;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got.status     = m_axis_tdata[0];
        got.temp_raw   = m_axis_tdata[16:1];
        got.hum_raw    = m_axis_tdata[32:17];
        got.temp_centi = m_axis_tdata[47:33];
        got.hum_centi  = m_axis_tdata[62:48];
        if (expected_readings.size() == 0) begin
          $error("result with no frame pending: tdata %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("status", want.status, got.status);
          check_field("temp_raw", want.temp_raw, got.temp_raw);
          check_field("hum_raw", want.hum_raw, got.hum_raw);
          check_field("temp_centi", want.temp_centi, got.temp_centi);
          check_field("hum_centi", want.hum_centi, got.hum_centi);
          if (want.status == hwtc_pkg::STATUS_CRC_ERR) readings_bad++;
          else readings_good++;
        end
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog: no request moved for %0d cycles", stall_cycles);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // Wait until every queued byte went in and every reading came out.
  task automatic drain();
    while (rx_items.size() > 0 || s_axis_tvalid || expected_readings.size() > 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed frames at the edges of the ranges, with no idling.
    push_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    // Back to back without a start flag.
    push_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
    // A frame cut short by a new start, which then fails its temperature CRC.
    push_byte(8'hA5, 1'b1);
    push_byte(8'h5A, 1'b0);
    push_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b0);
    // Humidity CRC failure only.
    push_frame(16'h8000, 16'h6666, 1'b1, 1'b0, 1'b1);
    drain();

    // Random traffic while the receiver holds off, then the idling phases.
    queue_random_traffic(480);
    rx_hold_req = 1'b1;
    drain();

    send_idle_pct = 64;
    recv_stall_pct = 0;
    queue_random_traffic(480);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 64;
    queue_random_traffic(480);
    drain();

    send_idle_pct = 29;
    recv_stall_pct = 29;
    queue_random_traffic(480);
    drain();

    repeat (10) @(posedge clk);
    $display("Sent %0d bytes through four handshake phases and a long receiver hold.",
             bytes_taken);
    $display("Checked %0d good frames and %0d frames with CRC errors.",
             readings_good, readings_bad);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
